/* hdl/osl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osl_pkg
// shared token and queue entry types for the operator string lexer
// ----------------------------------------------------------------------------
package osl_pkg;

    localparam int unsigned FIELD_WIDTH = 32;
    localparam int unsigned KIND_WIDTH  = 5;

    // pending comparison operators, in kind order from KIND_OP_SINGLE
    localparam logic [1:0] OP_BANG  = 2'd0;
    localparam logic [1:0] OP_EQUAL = 2'd1;
    localparam logic [1:0] OP_LESS  = 2'd2;
    localparam logic [1:0] OP_GREAT = 2'd3;

    // token kinds
    localparam logic [KIND_WIDTH-1:0] KIND_LPAREN    = 5'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_RPAREN    = 5'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_LBRACE    = 5'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_RBRACE    = 5'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_COMMA     = 5'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_DOT       = 5'd5;
    localparam logic [KIND_WIDTH-1:0] KIND_MINUS     = 5'd6;
    localparam logic [KIND_WIDTH-1:0] KIND_PLUS      = 5'd7;
    localparam logic [KIND_WIDTH-1:0] KIND_SEMI      = 5'd8;
    localparam logic [KIND_WIDTH-1:0] KIND_STAR      = 5'd9;
    localparam logic [KIND_WIDTH-1:0] KIND_OP_SINGLE = 5'd10;
    localparam logic [KIND_WIDTH-1:0] KIND_OP_DOUBLE = 5'd11;
    localparam logic [KIND_WIDTH-1:0] KIND_SLASH     = 5'd18;
    localparam logic [KIND_WIDTH-1:0] KIND_STRING    = 5'd19;
    localparam logic [KIND_WIDTH-1:0] KIND_END       = 5'd20;
    localparam logic [KIND_WIDTH-1:0] KIND_ERR_CHAR  = 5'd21;
    localparam logic [KIND_WIDTH-1:0] KIND_ERR_LF    = 5'd22;
    localparam logic [KIND_WIDTH-1:0] KIND_ERR_UNTRM = 5'd23;

    // one token as it leaves the block
    typedef struct packed {
        logic [KIND_WIDTH-1:0]  kind;
        logic [FIELD_WIDTH-1:0] start;
        logic [FIELD_WIDTH-1:0] length;
        logic [FIELD_WIDTH-1:0] line;
    } token_t;

    // tokens caused by one input item; tok0 always used, tok1 only when two
    typedef struct packed {
        logic   two;
        token_t tok0;
        token_t tok1;
    } entry_t;

endpackage : osl_pkg
`default_nettype wire

/* hdl/operator_string_lexer.sv */
`timescale 1ns / 1ps
`default_nettype none
// path: an item's tokens are written to the queue, then to the output stage register that drives the result ports
// throughput: one item per cycle into the scanner while full is low; one token per cycle
//   out while pop is high and tokens wait, so an item giving two tokens takes two transfers
// the small state register in the scanner is the only loop between items
// reset: asynchronous, active low; scan state returns to normal, line 1,
//   position 0, and the queue and output stage come up empty
// ----------------------------------------------------------------------------
// operator_string_lexer
// streaming lexer for punctuation, comparison operators, comments and strings
// ----------------------------------------------------------------------------
module operator_string_lexer
    import osl_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = 32,
    parameter int unsigned QUEUE_DEPTH    = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input side: a transfer when push is high and full is low
    input  wire logic                   push,
    output logic                        full,
    input  wire logic                   command,
    input  wire logic [7:0]             char_code,
    // result side: a transfer when pop is high and empty is low
    output logic                        empty,
    input  wire logic                   pop,
    output logic [KIND_WIDTH-1:0]       token_kind,
    output logic [FIELD_WIDTH-1:0]      start_offset,
    output logic [FIELD_WIDTH-1:0]      lexeme_length,
    output logic [FIELD_WIDTH-1:0]      line_number,
    output logic                        last_of_run
);

    // scanner to queue
    logic   enq_valid;
    entry_t enq_entry;
    logic   q_full;

    // queue to output stage
    logic   q_rd;
    logic   q_not_empty;
    entry_t q_entry;

    // front: classifies each byte and builds up to two tokens per item
    osl_front #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .command   (command),
        .char_code (char_code),
        .q_full    (q_full),
        .full      (full),
        .enq_valid (enq_valid),
        .enq_entry (enq_entry)
    );

    // queue decouples scanner stalls from the result side
    osl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (enq_valid),
        .wr_entry  (enq_entry),
        .rd        (q_rd),
        .rd_entry  (q_entry),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    // back: serialises each entry into single-token transfers
    osl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_entry       (q_entry),
        .q_rd          (q_rd),
        .pop           (pop),
        .empty         (empty),
        .token_kind    (token_kind),
        .start_offset  (start_offset),
        .lexeme_length (lexeme_length),
        .line_number   (line_number),
        .last_of_run   (last_of_run)
    );

endmodule : operator_string_lexer
`default_nettype wire

/* hdl/osl_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osl_front
// scanner: accepts one item a cycle while the queue is not full, tracks scan state, builds token entries
// ----------------------------------------------------------------------------
module osl_front
    import osl_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic         command,
    input  wire logic [7:0]   char_code,
    input  wire logic         q_full,
    output logic              full,
    output logic              enq_valid,
    output entry_t            enq_entry
);

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_OPER    = 3'd1,
        MODE_SLASH   = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_STRING  = 3'd4
    } mode_t;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GREAT  = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    localparam logic [POSITION_WIDTH-1:0] POS_ONE  = POSITION_WIDTH'(1);
    localparam logic [POSITION_WIDTH-1:0] POS_TWO  = POSITION_WIDTH'(2);
    localparam logic [POSITION_WIDTH-1:0] POS_ZERO = '0;
    localparam logic [FIELD_WIDTH-1:0]    LINE_ONE = FIELD_WIDTH'(1);

    mode_t                     mode_reg,  mode_next;
    logic [1:0]                pend_reg,  pend_next;
    logic [POSITION_WIDTH-1:0] pos_reg,   pos_next;
    logic [POSITION_WIDTH-1:0] start_reg, start_next;
    logic [FIELD_WIDTH-1:0]    line_reg,  line_next;

    logic                      accept;
    logic                      rescan;
    logic                      a_valid, b_valid;
    logic [KIND_WIDTH-1:0]     a_kind,  b_kind;
    logic [POSITION_WIDTH-1:0] a_len,   b_len, b_start;
    logic [KIND_WIDTH-1:0]     op_kind;
    token_t                    a_tok, b_tok;

    // position to output field: zero-extend or truncate to 32 bits
    function automatic logic [FIELD_WIDTH-1:0] to_field(input logic [POSITION_WIDTH-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[FIELD_WIDTH-1:0];
    endfunction

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign op_kind = KIND_OP_SINGLE + {2'b00, pend_reg, 1'b0};

    always_comb
    begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        pos_next   = pos_reg + POS_ONE;
        start_next = start_reg;
        line_next  = line_reg;
        rescan     = 1'b0;
        a_valid    = 1'b0;
        a_kind     = KIND_SLASH;
        a_len      = POS_ONE;
        b_valid    = 1'b0;
        b_kind     = KIND_ERR_CHAR;
        b_len      = POS_ONE;
        b_start    = pos_reg;

        if (command)
        begin
            // end of source: flush pending lexeme, then the end token
            case (mode_reg)
                MODE_OPER:
                begin
                    a_valid = 1'b1;
                    a_kind  = op_kind;
                end
                MODE_SLASH:
                begin
                    a_valid = 1'b1;
                    a_kind  = KIND_SLASH;
                end
                MODE_STRING:
                begin
                    a_valid = 1'b1;
                    a_kind  = KIND_ERR_UNTRM;
                    a_len   = pos_reg - start_reg;
                end
                default:
                begin
                    a_valid = 1'b0;
                end
            endcase
            b_valid    = 1'b1;
            b_kind     = KIND_END;
            b_len      = POS_ZERO;
            mode_next  = MODE_NORMAL;
            pend_next  = OP_BANG;
            pos_next   = POS_ZERO;
            start_next = POS_ZERO;
            line_next  = LINE_ONE;
        end
        else
        begin
            rescan = 1'b1;
            case (mode_reg)
                MODE_OPER:
                begin
                    mode_next = MODE_NORMAL;
                    a_valid   = 1'b1;
                    if (char_code == CH_EQUAL)
                    begin
                        a_kind = op_kind + (KIND_OP_DOUBLE - KIND_OP_SINGLE);
                        a_len  = POS_TWO;
                        rescan = 1'b0;
                    end
                    else
                    begin
                        a_kind = op_kind;
                    end
                end
                MODE_SLASH:
                begin
                    if (char_code == CH_SLASH)
                    begin
                        mode_next = MODE_COMMENT;
                        rescan    = 1'b0;
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                        a_valid   = 1'b1;
                        a_kind    = KIND_SLASH;
                    end
                end
                MODE_COMMENT:
                begin
                    if (char_code == CH_LF)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                    else
                    begin
                        rescan = 1'b0;
                    end
                end
                MODE_STRING:
                begin
                    if (char_code == CH_QUOTE)
                    begin
                        mode_next = MODE_NORMAL;
                        a_valid   = 1'b1;
                        a_kind    = KIND_STRING;
                        a_len     = pos_reg + POS_ONE - start_reg;
                        rescan    = 1'b0;
                    end
                    else if (char_code == CH_LF)
                    begin
                        mode_next = MODE_NORMAL;
                        a_valid   = 1'b1;
                        a_kind    = KIND_ERR_LF;
                        a_len     = pos_reg - start_reg;
                    end
                    else
                    begin
                        rescan = 1'b0;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase

            if (rescan)
            begin
                start_next = pos_reg;
                b_valid    = 1'b1;
                case (char_code)
                    CH_LPAREN: b_kind = KIND_LPAREN;
                    CH_RPAREN: b_kind = KIND_RPAREN;
                    CH_LBRACE: b_kind = KIND_LBRACE;
                    CH_RBRACE: b_kind = KIND_RBRACE;
                    CH_COMMA:  b_kind = KIND_COMMA;
                    CH_DOT:    b_kind = KIND_DOT;
                    CH_MINUS:  b_kind = KIND_MINUS;
                    CH_PLUS:   b_kind = KIND_PLUS;
                    CH_SEMI:   b_kind = KIND_SEMI;
                    CH_STAR:   b_kind = KIND_STAR;
                    CH_BANG:
                    begin
                        b_valid   = 1'b0;
                        mode_next = MODE_OPER;
                        pend_next = OP_BANG;
                    end
                    CH_EQUAL:
                    begin
                        b_valid   = 1'b0;
                        mode_next = MODE_OPER;
                        pend_next = OP_EQUAL;
                    end
                    CH_LESS:
                    begin
                        b_valid   = 1'b0;
                        mode_next = MODE_OPER;
                        pend_next = OP_LESS;
                    end
                    CH_GREAT:
                    begin
                        b_valid   = 1'b0;
                        mode_next = MODE_OPER;
                        pend_next = OP_GREAT;
                    end
                    CH_SLASH:
                    begin
                        b_valid   = 1'b0;
                        mode_next = MODE_SLASH;
                    end
                    CH_SPACE, CH_CR, CH_TAB:
                    begin
                        b_valid = 1'b0;
                    end
                    CH_LF:
                    begin
                        b_valid = 1'b0;
                        if (line_reg != '1)
                        begin
                            line_next = line_reg + LINE_ONE;
                        end
                    end
                    CH_QUOTE:
                    begin
                        b_valid   = 1'b0;
                        mode_next = MODE_STRING;
                    end
                    default:   b_kind = KIND_ERR_CHAR;
                endcase
            end
        end
    end

    // every token of one item carries the line count from before the item
    always_comb
    begin
        a_tok.kind   = a_kind;
        a_tok.start  = to_field(start_reg);
        a_tok.length = to_field(a_len);
        a_tok.line   = line_reg;
        b_tok.kind   = b_kind;
        b_tok.start  = to_field(b_start);
        b_tok.length = to_field(b_len);
        b_tok.line   = line_reg;

        enq_valid = accept && (a_valid || b_valid);
        if (a_valid)
        begin
            enq_entry.two  = b_valid;
            enq_entry.tok0 = a_tok;
            enq_entry.tok1 = b_tok;
        end
        else
        begin
            enq_entry.two  = 1'b0;
            enq_entry.tok0 = b_tok;
            enq_entry.tok1 = b_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            pend_reg  <= OP_BANG;
            pos_reg   <= POS_ZERO;
            start_reg <= POS_ZERO;
            line_reg  <= LINE_ONE;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            line_reg  <= line_next;
        end
    end

endmodule : osl_front
`default_nettype wire

/* hdl/osl_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osl_queue
// small entry queue between the scanner and the output stage
// ----------------------------------------------------------------------------
module osl_queue
    import osl_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr,
    input  wire entry_t wr_entry,
    input  wire logic   rd,
    output entry_t      rd_entry,
    output logic        full,
    output logic        not_empty
);

    localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
    localparam logic [PTR_WIDTH-1:0] PTR_ONE  = PTR_WIDTH'(1);
    localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);
    localparam logic [CNT_WIDTH-1:0] CNT_ONE  = CNT_WIDTH'(1);

    entry_t               slot_reg [DEPTH];
    logic [PTR_WIDTH-1:0] wptr_reg, wptr_next;
    logic [PTR_WIDTH-1:0] rptr_reg, rptr_next;
    logic [CNT_WIDTH-1:0] cnt_reg,  cnt_next;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign rd_entry  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PTR_ONE;
        rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + PTR_ONE;
        cnt_next  = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + CNT_ONE;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= wptr_next;
            end
            if (rd)
            begin
                rptr_reg <= rptr_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("queue count above depth");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> !full)
        else $error("queue written while full");

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> not_empty)
        else $error("queue read while empty");

endmodule : osl_queue
`default_nettype wire

/* hdl/osl_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osl_back
// output stage: holds one entry and hands out its tokens one transfer each
// ----------------------------------------------------------------------------
module osl_back
    import osl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_not_empty,
    input  wire entry_t                 q_entry,
    output logic                        q_rd,
    input  wire logic                   pop,
    output logic                        empty,
    output logic [KIND_WIDTH-1:0]       token_kind,
    output logic [FIELD_WIDTH-1:0]      start_offset,
    output logic [FIELD_WIDTH-1:0]      lexeme_length,
    output logic [FIELD_WIDTH-1:0]      line_number,
    output logic                        last_of_run
);

    entry_t entry_reg;
    logic   valid_reg;
    logic   idx_reg;
    logic   take;
    logic   load_ok;
    token_t cur;

    assign cur           = idx_reg ? entry_reg.tok1 : entry_reg.tok0;
    assign empty         = !valid_reg;
    assign token_kind    = cur.kind;
    assign start_offset  = cur.start;
    assign lexeme_length = cur.length;
    assign line_number   = cur.line;
    assign last_of_run   = idx_reg || !entry_reg.two;

    assign take    = pop && valid_reg;
    assign load_ok = !valid_reg || (take && last_of_run);
    assign q_rd    = q_not_empty && load_ok;

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            entry_reg <= q_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else if (load_ok)
        begin
            valid_reg <= q_not_empty;
            idx_reg   <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= 1'b1;
        end
    end

    a_second_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && idx_reg) |-> entry_reg.two)
        else $error("second token selected from a single-token entry");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> (!valid_reg || (pop && last_of_run)))
        else $error("entry loaded over an unfinished one");

    a_advance_second: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last_of_run) |=> (valid_reg && idx_reg))
        else $error("second token lost after first transfer");

endmodule : osl_back
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the operator string lexer: a queue of source bytes
// and end markers feeds a clocked driver, a clocked monitor predicts the
// tokens of every accepted transfer and compares each popped token with them
// ----------------------------------------------------------------------------
module tb_top
    import osl_pkg::*;
;

    localparam int unsigned RESET_CYCLES  = 11;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 250000;

    // input commands
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // source characters
    localparam logic [7:0] CH_LPAREN  = "(";
    localparam logic [7:0] CH_RPAREN  = ")";
    localparam logic [7:0] CH_LBRACE  = "{";
    localparam logic [7:0] CH_RBRACE  = "}";
    localparam logic [7:0] CH_COMMA   = ",";
    localparam logic [7:0] CH_DOT     = ".";
    localparam logic [7:0] CH_MINUS   = "-";
    localparam logic [7:0] CH_PLUS    = "+";
    localparam logic [7:0] CH_SEMI    = ";";
    localparam logic [7:0] CH_STAR    = "*";
    localparam logic [7:0] CH_BANG    = "!";
    localparam logic [7:0] CH_EQUAL   = "=";
    localparam logic [7:0] CH_LESS    = "<";
    localparam logic [7:0] CH_GREATER = ">";
    localparam logic [7:0] CH_SLASH   = "/";
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // character pools for the random sources
    localparam logic [8*10-1:0] PUNCT_SET   = "(){},.-+;*";
    localparam logic [8*4-1:0]  OPER_SET    = "!=<>";
    localparam logic [8*3-1:0]  BLANK_SET   = {CH_SPACE, CH_TAB, CH_CR};
    localparam logic [8*19-1:0] SPECIAL_SET = "(){},.-+;*!=<>/\" \n\t";

    typedef enum logic [2:0] {
        SCAN_NORMAL,
        SCAN_OPER,
        SCAN_SLASH,
        SCAN_COMMENT,
        SCAN_STRING
    } scan_mode_t;

    typedef struct packed {
        logic                   cmd;
        logic [7:0]             code;
    } lex_item_t;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]  kind;
        logic [FIELD_WIDTH-1:0] start;
        logic [FIELD_WIDTH-1:0] length;
        logic [FIELD_WIDTH-1:0] line;
        logic                   last;
    } lex_token_t;

    // block ports
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   push      = 1'b0;
    logic                   full;
    logic                   command   = CMD_CHAR;
    logic [7:0]             char_code = 8'h00;
    logic                   empty;
    logic                   pop       = 1'b0;
    logic [KIND_WIDTH-1:0]  token_kind;
    logic [FIELD_WIDTH-1:0] start_offset;
    logic [FIELD_WIDTH-1:0] lexeme_length;
    logic [FIELD_WIDTH-1:0] line_number;
    logic                   last_of_run;

    // stimulus and scoreboard
    lex_item_t   pending_items[$];
    lex_token_t  expected_tokens[$];
    int unsigned items_queued   = 0;
    int unsigned items_accepted = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    logic        item_taken     = 1'b0;
    logic        calm           = 1'b0;
    int unsigned send_gap       = 0;
    int unsigned pop_gap        = 0;
    int unsigned hold_left      = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_seen      = 0;

    // predicted scanner state
    scan_mode_t             scan_state   = SCAN_NORMAL;
    logic [1:0]             pend_op      = OP_BANG;
    logic [FIELD_WIDTH-1:0] byte_pos     = '0;
    logic [FIELD_WIDTH-1:0] lexeme_start = '0;
    logic [FIELD_WIDTH-1:0] line_cnt     = 1;

    operator_string_lexer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .char_code     (char_code),
        .empty         (empty),
        .pop           (pop),
        .token_kind    (token_kind),
        .start_offset  (start_offset),
        .lexeme_length (lexeme_length),
        .line_number   (line_number),
        .last_of_run   (last_of_run)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // token prediction
    // ------------------------------------------------------------------------

    function automatic lex_token_t make_token(input logic [KIND_WIDTH-1:0] kind,
                                              input logic [FIELD_WIDTH-1:0] start,
                                              input logic [FIELD_WIDTH-1:0] length);
        lex_token_t tok;
        tok.kind   = kind;
        tok.start  = start;
        tok.length = length;
        tok.line   = line_cnt;
        tok.last   = 1'b0;
        return tok;
    endfunction

    // one-character operator kinds sit on even codes, the '=' forms just above
    function automatic logic [KIND_WIDTH-1:0] oper_kind(input logic [1:0] op,
                                                        input logic wide);
        return KIND_OP_SINGLE + {2'b00, op, 1'b0} + {4'b0000, wide};
    endfunction

    // works out the tokens of one accepted transfer and queues them in order
    task automatic lex_predict(input logic cmd, input logic [7:0] ch);
        lex_token_t             found[$];
        logic [FIELD_WIDTH-1:0] at;
        logic                   rescan;
        at     = byte_pos;
        rescan = 1'b1;
        if (cmd == CMD_END)
        begin
            // whatever is still open is closed before the end token
            case (scan_state)
                SCAN_OPER:
                    found = {found, make_token(oper_kind(pend_op, 1'b0), lexeme_start, 1)};
                SCAN_SLASH:
                    found = {found, make_token(KIND_SLASH, lexeme_start, 1)};
                SCAN_STRING:
                    found = {found, make_token(KIND_ERR_UNTRM, lexeme_start,
                                               at - lexeme_start)};
                default:
                    ;
            endcase
            found = {found, make_token(KIND_END, at, 0)};
            // next source starts from scratch
            scan_state   = SCAN_NORMAL;
            pend_op      = OP_BANG;
            byte_pos     = '0;
            lexeme_start = '0;
            line_cnt     = 1;
        end
        else
        begin
            case (scan_state)
                SCAN_OPER:
                begin
                    scan_state = SCAN_NORMAL;
                    if (ch == CH_EQUAL)
                    begin
                        found = {found,
                                 make_token(oper_kind(pend_op, 1'b1), lexeme_start, 2)};
                        rescan = 1'b0;
                    end
                    else
                    begin
                        found = {found,
                                 make_token(oper_kind(pend_op, 1'b0), lexeme_start, 1)};
                    end
                end
                SCAN_SLASH:
                begin
                    if (ch == CH_SLASH)
                    begin
                        scan_state = SCAN_COMMENT;
                        rescan     = 1'b0;
                    end
                    else
                    begin
                        scan_state = SCAN_NORMAL;
                        found = {found, make_token(KIND_SLASH, lexeme_start, 1)};
                    end
                end
                SCAN_COMMENT:
                begin
                    // the newline itself is scanned again and counts a line
                    if (ch == CH_NEWLINE)
                        scan_state = SCAN_NORMAL;
                    else
                        rescan = 1'b0;
                end
                SCAN_STRING:
                begin
                    if (ch == CH_QUOTE)
                    begin
                        scan_state = SCAN_NORMAL;
                        found = {found, make_token(KIND_STRING, lexeme_start,
                                                   at + 1 - lexeme_start)};
                        rescan = 1'b0;
                    end
                    else if (ch == CH_NEWLINE)
                    begin
                        scan_state = SCAN_NORMAL;
                        found = {found, make_token(KIND_ERR_LF, lexeme_start,
                                                   at - lexeme_start)};
                    end
                    else
                    begin
                        rescan = 1'b0;
                    end
                end
                default:
                    scan_state = SCAN_NORMAL;
            endcase
            if (rescan)
            begin
                lexeme_start = at;
                case (ch)
                    CH_LPAREN:  found = {found, make_token(KIND_LPAREN, at, 1)};
                    CH_RPAREN:  found = {found, make_token(KIND_RPAREN, at, 1)};
                    CH_LBRACE:  found = {found, make_token(KIND_LBRACE, at, 1)};
                    CH_RBRACE:  found = {found, make_token(KIND_RBRACE, at, 1)};
                    CH_COMMA:   found = {found, make_token(KIND_COMMA, at, 1)};
                    CH_DOT:     found = {found, make_token(KIND_DOT, at, 1)};
                    CH_MINUS:   found = {found, make_token(KIND_MINUS, at, 1)};
                    CH_PLUS:    found = {found, make_token(KIND_PLUS, at, 1)};
                    CH_SEMI:    found = {found, make_token(KIND_SEMI, at, 1)};
                    CH_STAR:    found = {found, make_token(KIND_STAR, at, 1)};
                    CH_BANG:
                    begin
                        scan_state = SCAN_OPER;
                        pend_op    = OP_BANG;
                    end
                    CH_EQUAL:
                    begin
                        scan_state = SCAN_OPER;
                        pend_op    = OP_EQUAL;
                    end
                    CH_LESS:
                    begin
                        scan_state = SCAN_OPER;
                        pend_op    = OP_LESS;
                    end
                    CH_GREATER:
                    begin
                        scan_state = SCAN_OPER;
                        pend_op    = OP_GREAT;
                    end
                    CH_SLASH:   scan_state = SCAN_SLASH;
                    CH_SPACE, CH_CR, CH_TAB:
                        ;
                    CH_NEWLINE:
                    begin
                        // line count saturates rather than wrapping
                        if (line_cnt != '1)
                            line_cnt = line_cnt + 1;
                    end
                    CH_QUOTE:   scan_state = SCAN_STRING;
                    default:    found = {found, make_token(KIND_ERR_CHAR, at, 1)};
                endcase
            end
            byte_pos = at + 1;
        end
        if (found.size() != 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            expected_tokens = {expected_tokens, found[i]};
    endtask

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        error_count++;
        $display("ERROR at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // driver: one item offered at a time, changed only at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_items
        lex_item_t nxt;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (!push || item_taken)
        begin
            // slot free: previous transfer done or nothing offered
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                push     <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                // idle burst: this slot is idle, and send_gap counts the idle slots after it
                send_gap <= $urandom_range(0, 15);
                push     <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                nxt       = pending_items.pop_front();
                push      <= 1'b1;
                command   <= nxt.cmd;
                char_code <= nxt.code;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // long receiver hold-off, counted here so the random pops stay simple
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end
    end

    // receiver: random stall bursts, none in the calm tail of the run
    always @(negedge clk)
    begin
        if (!rst_n || hold_left != 0 || hold_req != hold_seen)
        begin
            pop <= 1'b0;
        end
        else if (pop_gap != 0)
        begin
            pop_gap <= pop_gap - 1;
            pop     <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            pop_gap <= $urandom_range(0, 15);
            pop     <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_transfers
        lex_token_t want;
        if (rst_n)
        begin
            // check the popped token before predicting, so a token with
            // nothing waiting is never matched against this cycle's item
            if (pop && !empty)
            begin
                if (expected_tokens.size() == 0)
                begin
                    flag_error("token with nothing expected, kind", 32'(token_kind), 0);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (token_kind !== want.kind)
                        flag_error("token_kind", 32'(token_kind), 32'(want.kind));
                    if (start_offset !== want.start)
                        flag_error("start_offset", start_offset, want.start);
                    if (lexeme_length !== want.length)
                        flag_error("lexeme_length", lexeme_length, want.length);
                    if (line_number !== want.line)
                        flag_error("line_number", line_number, want.line);
                    if (last_of_run !== want.last)
                        flag_error("last_of_run", 32'(last_of_run), 32'(want.last));
                end
            end
            if (push && !full)
            begin
                lex_predict(command, char_code);
                items_accepted++;
            end
        end
        item_taken <= rst_n && push && !full;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d tokens outstanding",
                     cycle_count, expected_tokens.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic queue_item(input logic cmd, input logic [7:0] code);
        lex_item_t item;
        item.cmd  = cmd;
        item.code = code;
        pending_items = {pending_items, item};
        items_queued++;
    endtask

    task automatic queue_text(input string text);
        for (int i = 0; i < text.len(); i++)
            queue_item(CMD_CHAR, text[i]);
    endtask

    // any byte that neither closes a string nor breaks it
    function automatic logic [7:0] string_byte();
        logic [7:0] code;
        do
            code = 8'($urandom_range(0, 255));
        while (code == CH_QUOTE || code == CH_NEWLINE);
        return code;
    endfunction

    // mostly well-formed sources with random content, some pure noise;
    // every source is closed with an end marker
    task automatic queue_sources(input int unsigned count);
        int unsigned goal;
        int unsigned stop;
        int unsigned n;
        int unsigned k;
        logic [7:0]  code;
        goal = items_queued + count;
        while (items_queued < goal)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: random bytes with stray end markers
                n = $urandom_range(1, 20);
                for (int i = 0; i < n; i++)
                    queue_item($urandom_range(0, 5) == 0 ? CMD_END : CMD_CHAR,
                               8'($urandom_range(0, 255)));
            end
            else
            begin
                stop = items_queued + $urandom_range(4, 40);
                while (items_queued < stop)
                begin
                    case ($urandom_range(0, 15))
                        0, 1, 2, 3:
                        begin
                            k = $urandom_range(0, 9);
                            queue_item(CMD_CHAR, PUNCT_SET[8*k +: 8]);
                        end
                        4, 5:
                        begin
                            k = $urandom_range(0, 3);
                            queue_item(CMD_CHAR, OPER_SET[8*k +: 8]);
                            if ($urandom_range(0, 1) == 0)
                                queue_item(CMD_CHAR, CH_EQUAL);
                        end
                        6:
                            queue_item(CMD_CHAR, CH_SLASH);
                        7:
                        begin
                            // line comment with arbitrary body
                            queue_item(CMD_CHAR, CH_SLASH);
                            queue_item(CMD_CHAR, CH_SLASH);
                            n = $urandom_range(0, 8);
                            for (int i = 0; i < n; i++)
                            begin
                                do
                                    code = 8'($urandom_range(0, 255));
                                while (code == CH_NEWLINE);
                                queue_item(CMD_CHAR, code);
                            end
                            queue_item(CMD_CHAR, CH_NEWLINE);
                        end
                        8, 9, 12:
                        begin
                            // closed string, or one broken by a newline
                            queue_item(CMD_CHAR, CH_QUOTE);
                            n = $urandom_range(0, 8);
                            for (int i = 0; i < n; i++)
                                queue_item(CMD_CHAR, string_byte());
                            queue_item(CMD_CHAR,
                                       $urandom_range(0, 2) == 0 ? CH_NEWLINE : CH_QUOTE);
                        end
                        10:
                        begin
                            k = $urandom_range(0, 2);
                            queue_item(CMD_CHAR, BLANK_SET[8*k +: 8]);
                        end
                        11:
                            queue_item(CMD_CHAR, CH_NEWLINE);
                        13:
                            queue_item(CMD_CHAR, 8'($urandom_range(0, 255)));
                        default:
                        begin
                            // dense runs of special characters
                            n = $urandom_range(1, 6);
                            for (int i = 0; i < n; i++)
                            begin
                                k = $urandom_range(0, 18);
                                queue_item(CMD_CHAR, SPECIAL_SET[8*k +: 8]);
                            end
                        end
                    endcase
                end
                // leave something open at the end now and then
                case ($urandom_range(0, 7))
                    0:
                    begin
                        queue_item(CMD_CHAR, CH_QUOTE);
                        n = $urandom_range(0, 6);
                        for (int i = 0; i < n; i++)
                            queue_item(CMD_CHAR, string_byte());
                    end
                    1:
                    begin
                        k = $urandom_range(0, 3);
                        queue_item(CMD_CHAR, OPER_SET[8*k +: 8]);
                    end
                    2:
                        queue_item(CMD_CHAR, CH_SLASH);
                    3:
                    begin
                        queue_item(CMD_CHAR, CH_SLASH);
                        queue_item(CMD_CHAR, CH_SLASH);
                        queue_item(CMD_CHAR, string_byte());
                    end
                    default:
                        ;
                endcase
            end
            queue_item(CMD_END, 8'($urandom_range(0, 255)));
        end
    endtask

    // sender stays quiet until every item is through and every token popped
    task automatic wait_idle();
        do
            @(negedge clk);
        while (items_accepted != items_queued || expected_tokens.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every punctuation mark, each operator alone and with '=',
        // a trailing operator closed by the end marker
        queue_text("(){},.-+;*!<>===!=<==>");
        queue_item(CMD_END, 8'hFF);
        // slash before another character, comment to newline, closed string,
        // newline inside a string, string left open at the end
        queue_text("/x//\n\"a\"\"\n\"");
        queue_item(CMD_END, 8'h00);
        wait_idle();

        queue_sources(450);
        wait_idle();

        // receiver holds off while the sender keeps offering, so the block
        // fills up and raises full
        hold_req++;
        queue_sources(150);
        wait_idle();

        queue_sources(600);
        wait_idle();

        // calm tail: no idling on either side
        calm = 1'b1;
        queue_sources(220);
        wait_idle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
